// ===== rtl/nfr_pkg.sv =====
package nfr_pkg;

  localparam int unsigned STORE_BYTES_DEF = 65536;
  localparam int unsigned PAGE_BYTES = 512;
  localparam int unsigned PW = $clog2(PAGE_BYTES);
  localparam int unsigned QDEPTH = 2;

  localparam logic [2:0] BUS_CMD  = 3'd0;
  localparam logic [2:0] BUS_ADDR = 3'd1;
  localparam logic [2:0] BUS_DRD  = 3'd2;
  localparam logic [2:0] BUS_DWR  = 3'd3;
  localparam logic [2:0] BUS_CCLR = 3'd4;
  localparam logic [2:0] BUS_CRD  = 3'd5;

  localparam logic [7:0] OP_READ          = 8'h00;
  localparam logic [7:0] OP_ERASE_SETUP   = 8'h60;
  localparam logic [7:0] OP_ERASE_CONFIRM = 8'hD0;
  localparam logic [7:0] OP_WRITE_SETUP   = 8'h80;
  localparam logic [7:0] OP_WRITE_CONFIRM = 8'h10;

  localparam logic [15:0] DONE_BITS = 16'h8080;
  localparam logic [7:0]  ERASED    = 8'hFF;

  typedef enum logic [2:0] {
    K_CMD, K_ADDR, K_DRD, K_DWR, K_CCLR, K_CRD, K_NOP
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic        wide;
    logic [15:0] value;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef struct packed {
    logic pop;
    logic ready;
  } back_ctl_t;

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_MOD, ST_SWEEP, ST_RD_LO, ST_RD_HI, ST_WR_LO
  } state_e;

  typedef enum logic [1:0] {
    SW_CLEAR, SW_FILL, SW_IN, SW_OUT
  } sweep_e;

endpackage

// ===== rtl/nfr_ram.sv =====
module nfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/nfr_front.sv =====
module nfr_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [2:0]         command_i,
  input  logic               wide_i,
  input  logic [15:0]        value_i,
  output logic               busy_o,
  input  nfr_pkg::back_ctl_t ctl_i,
  output nfr_pkg::head_t     head_o
);
  import nfr_pkg::*;

  localparam int unsigned QPW = $clog2(QDEPTH);
  localparam int unsigned CW  = $clog2(QDEPTH + 1);

  item_t          q_q [QDEPTH];
  logic [QPW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  kind_e          kind;
  logic           full, push;

  // sort bus accesses into request kinds
  always_comb begin
    unique case (command_i)
      BUS_CMD:  kind = K_CMD;
      BUS_ADDR: kind = K_ADDR;
      BUS_DRD:  kind = K_DRD;
      BUS_DWR:  kind = K_DWR;
      BUS_CCLR: kind = K_CCLR;
      BUS_CRD:  kind = K_CRD;
      default:  kind = K_NOP;
    endcase
  end

  assign full   = (cnt_q == CW'(QDEPTH));
  assign busy_o = !ctl_i.ready || full;
  assign push   = start_i && !busy_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == QPW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (ctl_i.pop) begin
      rd_d = (rd_q == QPW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    unique case ({push, ctl_i.pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_q] <= '{kind: kind, wide: wide_i, value: value_i};
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = q_q[rd_q];

endmodule

// ===== rtl/nfr_mod.sv =====
module nfr_mod #(
  parameter int unsigned STORE_BYTES = nfr_pkg::STORE_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [31:0]                    base_i,
  output logic                           done_o,
  output logic [$clog2(STORE_BYTES)-1:0] rem_o
);

  localparam int unsigned AW    = $clog2(STORE_BYTES);
  localparam logic [31:0] MODC  = 32'(STORE_BYTES);
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(STORE_BYTES));

  logic [31:0]   opnd_q, opnd_d;
  logic [31:0]   quot_q, quot_d;
  logic [31:0]   qn_q, qn_d;
  logic [AW-1:0] rem_q, rem_d;
  logic          s1_q, s1_d, s2_q, s2_d, s3_q, s3_d, done_q, done_d;
  logic [63:0]   prod;
  logic [31:0]   diff;

  // reciprocal estimate is low by at most one, so one correction step
  assign prod = 64'(opnd_q) * 64'(RECIP);
  assign diff = opnd_q - qn_q;

  always_comb begin
    opnd_d = opnd_q;
    quot_d = quot_q;
    qn_d   = qn_q;
    rem_d  = rem_q;
    s1_d   = 1'b0;
    s2_d   = 1'b0;
    s3_d   = 1'b0;
    done_d = 1'b0;
    if (start_i) begin
      opnd_d = base_i;
      s1_d   = 1'b1;
    end
    if (s1_q) begin
      quot_d = 32'(prod >> 32);
      s2_d   = 1'b1;
    end
    if (s2_q) begin
      qn_d = quot_q * MODC;
      s3_d = 1'b1;
    end
    if (s3_q) begin
      rem_d  = (diff >= MODC) ? AW'(diff - MODC) : AW'(diff);
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opnd_q <= '0;
      quot_q <= '0;
      qn_q   <= '0;
      rem_q  <= '0;
      s1_q   <= 1'b0;
      s2_q   <= 1'b0;
      s3_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      opnd_q <= opnd_d;
      quot_q <= quot_d;
      qn_q   <= qn_d;
      rem_q  <= rem_d;
      s1_q   <= s1_d;
      s2_q   <= s2_d;
      s3_q   <= s3_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/nfr_back.sv =====
module nfr_back #(
  parameter int unsigned STORE_BYTES = nfr_pkg::STORE_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nfr_pkg::head_t     head_i,
  output nfr_pkg::back_ctl_t ctl_o,
  output logic               res_valid_o,
  output logic [15:0]        read_data_o,
  output logic               access_ignored_o,
  output logic               unknown_command_o
);
  import nfr_pkg::*;

  localparam int unsigned AW = $clog2(STORE_BYTES);

  state_e      state_q, state_d;
  sweep_e      sweep_q, sweep_d;
  logic [7:0]  cur_q, cur_d;
  logic [31:0] acc_q, acc_d;
  logic [1:0]  bcnt_q, bcnt_d;
  logic        active_q, active_d;
  logic [PW-1:0] ptr_q, ptr_d;
  logic [15:0] data_q, data_d;
  logic [15:0] stat_q, stat_d;
  logic [AW-1:0] fa_q, fa_d, fw_q, fw_d, fa_inc;
  logic [PW:0] i_q, i_d;
  logic [7:0]  lo_q, lo_d;
  logic        wide_q, wide_d;
  logic        res_valid_q, res_valid_d, res_ign_q, res_ign_d, res_unk_q, res_unk_d;
  logic [15:0] res_data_q, res_data_d;

  logic          buf_we, fl_we;
  logic [PW-1:0] buf_waddr, buf_raddr;
  logic [7:0]    buf_wdata, buf_rdata, fl_wdata, fl_rdata;
  logic [AW-1:0] fl_waddr, mod_rem;
  logic          mod_start, mod_done;
  logic [31:0]   mod_base;

  item_t       item;
  logic [7:0]  abyte;
  logic [4:0]  shamt;
  logic [31:0] acc_addr;

  assign item  = head_i.item;
  assign abyte = item.value[7:0];
  assign shamt = ((cur_q == OP_ERASE_SETUP) ? 5'd8 : 5'd9) + {bcnt_q - 2'd1, 3'b000};
  assign acc_addr = (bcnt_q == 2'd0) ? (acc_q | {24'b0, abyte})
                                     : (acc_q | (32'(abyte) << shamt));
  assign fa_inc = (fa_q == AW'(STORE_BYTES - 1)) ? '0 : fa_q + 1'b1;

  always_comb begin
    logic        do_launch;
    logic [7:0]  lcmd;
    logic [31:0] acc_new;
    do_launch   = 1'b0;
    lcmd        = cur_q;
    acc_new     = acc_q;
    state_d     = state_q;
    sweep_d     = sweep_q;
    cur_d       = cur_q;
    acc_d       = acc_q;
    bcnt_d      = bcnt_q;
    active_d    = active_q;
    ptr_d       = ptr_q;
    data_d      = data_q;
    stat_d      = stat_q;
    fa_d        = fa_q;
    fw_d        = fw_q;
    i_d         = i_q;
    lo_d        = lo_q;
    wide_d      = wide_q;
    res_valid_d = 1'b0;
    res_ign_d   = 1'b0;
    res_unk_d   = 1'b0;
    res_data_d  = res_data_q;
    buf_we      = 1'b0;
    buf_waddr   = ptr_q;
    buf_wdata   = '0;
    buf_raddr   = ptr_q;
    fl_we       = 1'b0;
    fl_waddr    = fa_q;
    fl_wdata    = ERASED;
    mod_start   = 1'b0;
    mod_base    = acc_q;
    ctl_o.pop   = 1'b0;
    ctl_o.ready = (state_q != ST_INIT);

    unique case (state_q)
      ST_INIT: begin
        // erase the store and zero the page buffer after reset
        fl_we     = 1'b1;
        buf_we    = 1'b1;
        buf_waddr = fa_q[PW-1:0];
        fa_d      = fa_inc;
        if (fa_q == AW'(STORE_BYTES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (head_i.valid) begin
          ctl_o.pop   = 1'b1;
          res_valid_d = 1'b1;
          res_data_d  = data_q;
          unique case (item.kind)
            K_CMD: begin
              cur_d = abyte;
              if (abyte == OP_ERASE_CONFIRM || abyte == OP_WRITE_CONFIRM) begin
                do_launch = 1'b1;
                lcmd      = abyte;
              end
            end
            K_ADDR: begin
              acc_d = acc_addr;
              if (bcnt_q == 2'd3) begin
                bcnt_d = '0;
                if (cur_q != OP_ERASE_SETUP) begin
                  do_launch = 1'b1;
                  acc_new   = acc_addr;
                end
              end else begin
                bcnt_d = bcnt_q + 1'b1;
              end
            end
            K_DRD: begin
              if (!active_q) begin
                res_ign_d = 1'b1;
              end else begin
                res_valid_d = 1'b0;
                wide_d      = item.wide;
                state_d     = ST_RD_LO;
              end
            end
            K_DWR: begin
              if (!active_q) begin
                res_ign_d = 1'b1;
              end else if (item.wide) begin
                res_valid_d = 1'b0;
                buf_we      = 1'b1;
                buf_wdata   = item.value[15:8];
                lo_d        = abyte;
                state_d     = ST_WR_LO;
              end else begin
                buf_we    = 1'b1;
                buf_wdata = abyte;
                ptr_d     = ptr_q + 1'b1;
              end
            end
            K_CCLR: begin
              stat_d     = stat_q & ~item.value;
              res_data_d = stat_q & ~item.value;
            end
            K_CRD:   res_data_d = stat_q;
            default: res_data_d = data_q;
          endcase

          if (do_launch) begin
            acc_d = '0;
            i_d   = '0;
            unique case (lcmd)
              OP_READ: begin
                res_valid_d = 1'b0;
                active_d    = 1'b1;
                ptr_d       = '0;
                stat_d      = stat_q | DONE_BITS;
                mod_start   = 1'b1;
                mod_base    = acc_new;
                sweep_d     = SW_IN;
                state_d     = ST_MOD;
              end
              OP_ERASE_CONFIRM: begin
                res_valid_d = 1'b0;
                stat_d      = stat_q | DONE_BITS;
                mod_start   = 1'b1;
                mod_base    = {acc_new[31-PW:0], PW'(0)};
                sweep_d     = SW_FILL;
                state_d     = ST_MOD;
              end
              OP_WRITE_SETUP: begin
                res_valid_d = 1'b0;
                active_d    = 1'b1;
                ptr_d       = '0;
                acc_d       = acc_new;
                sweep_d     = SW_CLEAR;
                state_d     = ST_SWEEP;
              end
              OP_WRITE_CONFIRM: begin
                res_valid_d = 1'b0;
                stat_d      = stat_q | DONE_BITS;
                mod_start   = 1'b1;
                mod_base    = acc_new;
                sweep_d     = SW_OUT;
                state_d     = ST_MOD;
              end
              default: res_unk_d = 1'b1;
            endcase
          end
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          fa_d    = mod_rem;
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        i_d = i_q + 1'b1;
        unique case (sweep_q)
          SW_CLEAR: begin
            buf_we    = 1'b1;
            buf_waddr = i_q[PW-1:0];
          end
          SW_FILL: begin
            buf_we    = 1'b1;
            buf_waddr = i_q[PW-1:0];
            buf_wdata = ERASED;
            fl_we     = 1'b1;
            fa_d      = fa_inc;
          end
          SW_IN: begin
            fa_d = fa_inc;
            if (i_q != '0) begin
              buf_we    = 1'b1;
              buf_waddr = PW'(i_q - 1'b1);
              buf_wdata = fl_rdata;
            end
          end
          default: begin
            buf_raddr = i_q[PW-1:0];
            fw_d      = fa_q;
            fa_d      = fa_inc;
            if (i_q != '0) begin
              fl_we    = 1'b1;
              fl_waddr = fw_q;
              fl_wdata = buf_rdata;
            end
          end
        endcase
        // copies end at i == PAGE_BYTES, not PAGE_BYTES - 1, to cover the registered read
        if (((sweep_q == SW_CLEAR || sweep_q == SW_FILL)
             && i_q == (PW + 1)'(PAGE_BYTES - 1))
            || i_q == (PW + 1)'(PAGE_BYTES)) begin
          state_d     = ST_IDLE;
          res_valid_d = 1'b1;
          res_data_d  = data_q;
        end
      end
      ST_RD_LO: begin
        if (!wide_q) begin
          data_d      = {8'b0, buf_rdata};
          ptr_d       = ptr_q + 1'b1;
          res_valid_d = 1'b1;
          res_data_d  = {8'b0, buf_rdata};
          state_d     = ST_IDLE;
        end else begin
          lo_d      = buf_rdata;
          buf_raddr = ptr_q + 1'b1;
          state_d   = ST_RD_HI;
        end
      end
      ST_RD_HI: begin
        data_d      = {buf_rdata, lo_q};
        ptr_d       = ptr_q + PW'(2);
        res_valid_d = 1'b1;
        res_data_d  = {buf_rdata, lo_q};
        state_d     = ST_IDLE;
      end
      default: begin
        buf_we      = 1'b1;
        buf_waddr   = ptr_q + 1'b1;
        buf_wdata   = lo_q;
        ptr_d       = ptr_q + PW'(2);
        res_valid_d = 1'b1;
        res_data_d  = data_q;
        state_d     = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      sweep_q     <= SW_CLEAR;
      cur_q       <= '0;
      acc_q       <= '0;
      bcnt_q      <= '0;
      active_q    <= 1'b0;
      ptr_q       <= '0;
      data_q      <= '0;
      stat_q      <= '0;
      fa_q        <= '0;
      fw_q        <= '0;
      i_q         <= '0;
      lo_q        <= '0;
      wide_q      <= 1'b0;
      res_valid_q <= 1'b0;
      res_ign_q   <= 1'b0;
      res_unk_q   <= 1'b0;
      res_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      cur_q       <= cur_d;
      acc_q       <= acc_d;
      bcnt_q      <= bcnt_d;
      active_q    <= active_d;
      ptr_q       <= ptr_d;
      data_q      <= data_d;
      stat_q      <= stat_d;
      fa_q        <= fa_d;
      fw_q        <= fw_d;
      i_q         <= i_d;
      lo_q        <= lo_d;
      wide_q      <= wide_d;
      res_valid_q <= res_valid_d;
      res_ign_q   <= res_ign_d;
      res_unk_q   <= res_unk_d;
      res_data_q  <= res_data_d;
    end
  end

  nfr_mod #(
    .STORE_BYTES (STORE_BYTES)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .base_i  (mod_base),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  nfr_ram #(
    .WIDTH (8),
    .DEPTH (PAGE_BYTES)
  ) u_page_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (buf_waddr),
    .wdata_i (buf_wdata),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  nfr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_flash (
    .clk_i   (clk_i),
    .we_i    (fl_we),
    .waddr_i (fl_waddr),
    .wdata_i (fl_wdata),
    .raddr_i (fa_q),
    .rdata_o (fl_rdata)
  );

  assign res_valid_o       = res_valid_q;
  assign read_data_o       = res_data_q;
  assign access_ignored_o  = res_ign_q;
  assign unknown_command_o = res_unk_q;

endmodule

// ===== rtl/nand_flash_register_model_top.sv =====
// register access: the request is popped in ST_IDLE and its result registered; byte reads
// also pass ST_RD_LO, halfword reads ST_RD_LO and ST_RD_HI, halfword writes ST_WR_LO;
// back end takes one request at a time off a 2-entry queue; page read, write confirm, erase:
// start address wrapped to the store size, then page copy; write setup clears the buffer
// reset: busy stays high while the store is erased and the buffer zeroed
// results are strobed for one cycle and the receiver cannot stall
module nand_flash_register_model_top #(
  parameter int unsigned STORE_BYTES = nfr_pkg::STORE_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [2:0]  command_i,
  input  logic        wide_i,
  input  logic [15:0] value_i,
  output logic        busy_o,
  output logic        res_valid_o,
  output logic [15:0] read_data_o,
  output logic        access_ignored_o,
  output logic        unknown_command_o
);
  import nfr_pkg::*;

  head_t     head;
  back_ctl_t ctl;

  nfr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (command_i),
    .wide_i    (wide_i),
    .value_i   (value_i),
    .busy_o    (busy_o),
    .ctl_i     (ctl),
    .head_o    (head)
  );

  nfr_back #(
    .STORE_BYTES (STORE_BYTES)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_i            (head),
    .ctl_o             (ctl),
    .res_valid_o       (res_valid_o),
    .read_data_o       (read_data_o),
    .access_ignored_o  (access_ignored_o),
    .unknown_command_o (unknown_command_o)
  );

endmodule
